// ===== rtl/core/gdfps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gdfps_pkg;

  // grid store and stack sizes
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int STACK_SIZE = 4096;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int STK_AW  = $clog2(STACK_SIZE);
  localparam int DEPTH_W = STK_AW + 1;

  // fixed field widths
  localparam int DIM_W  = 7;
  localparam int CELL_W = 6;
  localparam int LEN_W  = 12;

  localparam logic [DIM_W-1:0] DIM_RESET  = 7'd64;
  localparam logic [DIM_W-1:0] GRID_LIMIT = 7'd64;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_MARK   = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MV_RIGHT = 2'd0,
    MV_DOWN  = 2'd1,
    MV_LEFT  = 2'd2,
    MV_UP    = 2'd3
  } move_t;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t             kind;
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
    logic [LEN_W-1:0]  move_index;
  } gdfps_in_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] path_length;
    move_t            move;
  } gdfps_out_t;

  typedef enum logic [3:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_CLR,
    ST_MARK_WR,
    ST_SRCH_LD,
    ST_STEP_RD,
    ST_STEP_EV,
    ST_POP,
    ST_READ_MV,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/grid_depth_first_path_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  gdfps_in_t  (kind, cell, move index)
// out_      output     out_valid / out_stall gdfps_out_t (found, path length, move)
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data (grid rows, cols)
//
// one item at a time; clear writes one map row per cycle; a search takes a read
// state and an evaluate state per forward step and adds a pop state per back-up step,
// as the map and stack memories have registered reads
// after reset a pass over every map row zeroes the map; items are held off meanwhile
// the next item is taken while a result still waits in the output register
// cfg_ready is always high; the user must write registers only while idle, the block itself does not enforce it

module grid_depth_first_path_search (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire gdfps_pkg::gdfps_in_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output gdfps_pkg::gdfps_out_t      out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire gdfps_pkg::cfg_reg_t   cfg_index,
  input  wire logic [6:0]            cfg_data
);

  import gdfps_pkg::*;

  state_t               state_r, state_nxt;
  logic [ROW_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [DIM_W-1:0]     rows_r, rows_nxt;
  logic [DIM_W-1:0]     cols_r, cols_nxt;
  logic [CELL_W-1:0]    start_row_r, start_row_nxt;
  logic [CELL_W-1:0]    start_col_r, start_col_nxt;
  logic [CELL_W-1:0]    pos_row_r, pos_row_nxt;
  logic [CELL_W-1:0]    pos_col_r, pos_col_nxt;
  logic [CELL_W-1:0]    goal_row_r, goal_row_nxt;
  logic [CELL_W-1:0]    goal_col_r, goal_col_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic                 found_r, found_nxt;
  logic [MAX_COLS-1:0]  cur_row_r, cur_row_nxt;
  move_t                move_r, move_nxt;
  logic                 out_valid_r, out_valid_nxt;
  gdfps_out_t           out_data_r, out_data_nxt;

  // map memory: one row of visited bits per entry
  logic [MAX_COLS-1:0]  map_mem [MAX_ROWS];
  logic                 map_we;
  logic [ROW_W-1:0]     map_waddr;
  logic [MAX_COLS-1:0]  map_wdata;
  logic                 map_re_a, map_re_b;
  logic [ROW_W-1:0]     map_raddr_a, map_raddr_b;
  logic [MAX_COLS-1:0]  map_rd_a_r, map_rd_b_r;

  // move stack memory
  move_t                stk_mem [STACK_SIZE];
  logic                 stk_we;
  logic [STK_AW-1:0]    stk_waddr;
  move_t                stk_wdata;
  logic                 stk_re;
  logic [STK_AW-1:0]    stk_raddr;
  move_t                stk_rd_r;

  logic                 accept;
  logic                 out_free;
  logic                 clr_last;
  logic [DIM_W-1:0]     rows_eff, cols_eff;
  logic [CELL_W-1:0]    col_p1, col_m1, row_p1, row_m1;
  logic                 can_right, can_down, can_left, can_up;
  logic                 can_move;
  move_t                step_mv;
  logic                 at_goal;
  logic                 read_hit;
  logic [DEPTH_W-1:0]   depth_dec;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign clr_last  = (clr_cnt_r == ROW_W'(MAX_ROWS - 1));

  // effective grid size
  assign rows_eff = (rows_r > GRID_LIMIT) ? GRID_LIMIT : rows_r;
  assign cols_eff = (cols_r > GRID_LIMIT) ? GRID_LIMIT : cols_r;

  // neighbor cells, wrapping where the guards exclude them anyway
  assign col_p1 = pos_col_r + CELL_W'(1);
  assign col_m1 = pos_col_r - CELL_W'(1);
  assign row_p1 = pos_row_r + CELL_W'(1);
  assign row_m1 = pos_row_r - CELL_W'(1);

  assign can_right = ((DIM_W+1)'(pos_col_r) + (DIM_W+1)'(2) < (DIM_W+1)'(cols_eff))
                     && !cur_row_r[col_p1];
  assign can_down  = ((DIM_W+1)'(pos_row_r) + (DIM_W+1)'(2) < (DIM_W+1)'(rows_eff))
                     && !map_rd_b_r[pos_col_r];
  assign can_left  = (pos_col_r >= CELL_W'(2)) && !cur_row_r[col_m1];
  assign can_up    = (pos_row_r >= CELL_W'(2)) && !map_rd_a_r[pos_col_r];
  assign can_move  = (can_right || can_down || can_left || can_up) && !depth_r[STK_AW];

  // fixed try order: right, down, left, up
  always_comb begin
    if (can_right) begin
      step_mv = MV_RIGHT;
    end else if (can_down) begin
      step_mv = MV_DOWN;
    end else if (can_left) begin
      step_mv = MV_LEFT;
    end else begin
      step_mv = MV_UP;
    end
  end

  assign at_goal   = (pos_row_r == goal_row_r) && (pos_col_r == goal_col_r);
  assign read_hit  = (DEPTH_W'(in_data.move_index) < depth_r);
  assign depth_dec = depth_r - DEPTH_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RST_CLR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.kind)
            KIND_CLEAR:  state_nxt = ST_CLR;
            KIND_MARK:   state_nxt = ST_MARK_WR;
            KIND_SEARCH: state_nxt = ST_SRCH_LD;
            KIND_READ:   state_nxt = read_hit ? ST_READ_MV : ST_FINISH;
            default:     state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_CLR: begin
        if (clr_last) state_nxt = ST_FINISH;
      end
      ST_MARK_WR: state_nxt = ST_FINISH;
      ST_SRCH_LD: state_nxt = ST_STEP_RD;
      ST_STEP_RD: state_nxt = ST_STEP_EV;
      ST_STEP_EV: begin
        if (at_goal) begin
          state_nxt = ST_FINISH;
        end else if (can_move) begin
          state_nxt = ST_STEP_RD;
        end else if (depth_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_POP:     state_nxt = ST_STEP_RD;
      ST_READ_MV: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    start_row_nxt = start_row_r;
    start_col_nxt = start_col_r;
    pos_row_nxt   = pos_row_r;
    pos_col_nxt   = pos_col_r;
    goal_row_nxt  = goal_row_r;
    goal_col_nxt  = goal_col_r;
    depth_nxt     = depth_r;
    found_nxt     = found_r;
    cur_row_nxt   = cur_row_r;
    move_nxt      = move_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    map_we        = 1'b0;
    map_waddr     = clr_cnt_r;
    map_wdata     = '0;
    map_re_a      = 1'b0;
    map_re_b      = 1'b0;
    map_raddr_a   = row_m1;
    map_raddr_b   = row_p1;
    stk_we        = 1'b0;
    stk_waddr     = depth_r[STK_AW-1:0];
    stk_wdata     = step_mv;
    stk_re        = 1'b0;
    stk_raddr     = depth_dec[STK_AW-1:0];

    // configuration transaction
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS: rows_nxt = cfg_data;
        REG_COLS: cols_nxt = cfg_data;
        default:  rows_nxt = rows_r;
      endcase
    end

    unique case (state_r)
      ST_RST_CLR, ST_CLR: begin
        map_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + ROW_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          move_nxt     = MV_RIGHT;
          goal_row_nxt = in_data.cell_row;
          goal_col_nxt = in_data.cell_col;
          unique case (in_data.kind)
            KIND_CLEAR: begin
              clr_cnt_nxt = '0;
            end
            KIND_MARK: begin
              map_re_a      = 1'b1;
              map_raddr_a   = in_data.cell_row;
              start_row_nxt = in_data.cell_row;
              start_col_nxt = in_data.cell_col;
            end
            KIND_SEARCH: begin
              map_re_a    = 1'b1;
              map_raddr_a = start_row_r;
              pos_row_nxt = start_row_r;
              pos_col_nxt = start_col_r;
              depth_nxt   = '0;
              found_nxt   = 1'b0;
            end
            KIND_READ: begin
              stk_re    = 1'b1;
              stk_raddr = in_data.move_index;
            end
            default: begin
              stk_re = 1'b0;
            end
          endcase
        end
      end
      ST_MARK_WR: begin
        map_we    = 1'b1;
        map_waddr = goal_row_r;
        map_wdata = map_rd_a_r | (MAX_COLS'(1) << goal_col_r);
      end
      ST_SRCH_LD: begin
        cur_row_nxt = map_rd_a_r;
      end
      ST_STEP_RD: begin
        map_re_a = 1'b1;
        map_re_b = 1'b1;
      end
      ST_STEP_EV: begin
        if (at_goal) begin
          found_nxt = 1'b1;
        end else if (can_move) begin
          // push the move and mark the cell entered
          stk_we    = 1'b1;
          depth_nxt = depth_r + DEPTH_W'(1);
          map_we    = 1'b1;
          case (step_mv)
            MV_RIGHT: begin
              map_waddr   = pos_row_r;
              map_wdata   = cur_row_r | (MAX_COLS'(1) << col_p1);
              cur_row_nxt = map_wdata;
              pos_col_nxt = col_p1;
            end
            MV_DOWN: begin
              map_waddr   = row_p1;
              map_wdata   = map_rd_b_r | (MAX_COLS'(1) << pos_col_r);
              cur_row_nxt = map_wdata;
              pos_row_nxt = row_p1;
            end
            MV_LEFT: begin
              map_waddr   = pos_row_r;
              map_wdata   = cur_row_r | (MAX_COLS'(1) << col_m1);
              cur_row_nxt = map_wdata;
              pos_col_nxt = col_m1;
            end
            default: begin
              map_waddr   = row_m1;
              map_wdata   = map_rd_a_r | (MAX_COLS'(1) << pos_col_r);
              cur_row_nxt = map_wdata;
              pos_row_nxt = row_m1;
            end
          endcase
        end else if (depth_r != '0) begin
          // dead end: pop the last move
          depth_nxt = depth_dec;
          stk_re    = 1'b1;
        end
      end
      ST_POP: begin
        // undo the popped move; row data for vertical moves is still held
        case (stk_rd_r)
          MV_RIGHT: pos_col_nxt = col_m1;
          MV_DOWN: begin
            pos_row_nxt = row_m1;
            cur_row_nxt = map_rd_a_r;
          end
          MV_LEFT:  pos_col_nxt = col_p1;
          default: begin
            pos_row_nxt = row_p1;
            cur_row_nxt = map_rd_b_r;
          end
        endcase
      end
      ST_READ_MV: begin
        move_nxt = stk_rd_r;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = found_r;
          out_data_nxt.path_length = depth_r[LEN_W-1:0];
          out_data_nxt.move        = move_r;
        end
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RST_CLR;
      clr_cnt_r   <= '0;
      rows_r      <= DIM_RESET;
      cols_r      <= DIM_RESET;
      start_row_r <= '0;
      start_col_r <= '0;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      depth_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      start_row_r <= start_row_nxt;
      start_col_r <= start_col_nxt;
      pos_row_r   <= pos_row_nxt;
      pos_col_r   <= pos_col_nxt;
      depth_r     <= depth_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    goal_row_r <= goal_row_nxt;
    goal_col_r <= goal_col_nxt;
    cur_row_r  <= cur_row_nxt;
    move_r     <= move_nxt;
    out_data_r <= out_data_nxt;
  end

  // map memory, two read ports
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re_a) map_rd_a_r <= map_mem[map_raddr_a];
    if (map_re_b) map_rd_b_r <= map_mem[map_raddr_b];
  end

  // move stack memory
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_r <= stk_mem[stk_raddr];
  end

  // a result only appears from the finishing state
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result posted outside finishing state");

  // a back-up step always follows a pop of exactly one move
  a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> ($past(depth_r) == depth_r + DEPTH_W'(1)))
    else $error("stack depth not reduced by one on back-up");

  // no path means an empty path
  a_not_found_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !found_r) |-> (depth_r == '0))
    else $error("path length nonzero without goal");

endmodule

`default_nettype wire
